@@ rtl/depth_to_color_registration_unit_macros.svh @@
// Assertion shorthands shared by the block.
`ifndef DEPTH_TO_COLOR_REGISTRATION_UNIT_MACROS_SVH
`define DEPTH_TO_COLOR_REGISTRATION_UNIT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define DTC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while in reset.
`define DTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dtc_pkg.sv @@
package dtc_pkg;

  localparam int unsigned DEF_DISTANCE_ENTRIES = 2048;
  localparam int unsigned DEF_FRAME_WIDTH      = 640;
  localparam int unsigned DEF_FRAME_HEIGHT     = 480;

  localparam int unsigned NO_READING = 2047;

  // field and datapath widths
  localparam int X_W       = 10;
  localparam int Y_W       = 9;
  localparam int RAW_W     = 11;
  localparam int ADDR_W    = 20;
  localparam int DIST_W    = 16;
  localparam int OX_W      = 19;
  localparam int OY_W      = 18;
  localparam int OXD_W     = OX_W + DIST_W;
  localparam int OYD_W     = OY_W + DIST_W;
  localparam int PXF_W     = OXD_W + 21;
  localparam int PYF_W     = OYD_W + 21;
  localparam int D_W       = 31;
  localparam int ROT_W     = 25;
  localparam int PROD_W    = D_W + ROT_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int QZ_W      = 34;
  localparam int NUM_W     = 52;
  localparam int DEN_W     = QZ_W + 8;
  localparam int REM_W     = 56;
  localparam int QUOT_BITS = 14;
  localparam int QUOT_W    = QUOT_BITS + 2;
  localparam int DIV_STEPS = 2;
  localparam int DIV_STAGES = QUOT_BITS / DIV_STEPS;
  localparam int P_W       = 25;

  // pipeline stage numbers
  localparam int ST_ROM     = 0;
  localparam int ST_OFS     = 1;
  localparam int ST_PROJ    = 6;
  localparam int ST_DIV0    = ST_PROJ + 1;
  localparam int DIV_LAT    = DIV_STAGES + 2;
  localparam int ST_CLAMP   = ST_DIV0 + DIV_LAT;
  localparam int ST_OUT     = ST_CLAMP + 1;
  localparam int NUM_STAGES = ST_OUT + 1;
  localparam int XFORM_LAT  = ST_PROJ - ST_OFS + 1;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint K3_Q30      = 64'sd1273779926;

  localparam logic signed [ROT_W-1:0] ROT_Q24 [3][3] = '{
    '{ 25'sd16774637,  25'sd21199,    -25'sd293387 },
    '{ -25'sd24795,    25'sd16775939, -25'sd205544 },
    '{ 25'sd293105,    25'sd205946,   25'sd16773391 } };
  localparam logic signed [15:0] TRANS_Q8 [3] = '{ 16'sd5116, -16'sd191, -16'sd2795 };

  typedef enum logic [3:0] {
    REG_INV_FOCAL_DEPTH_X = 4'd0,
    REG_INV_FOCAL_DEPTH_Y = 4'd1,
    REG_CENTER_DEPTH_X    = 4'd2,
    REG_CENTER_DEPTH_Y    = 4'd3,
    REG_FOCAL_COLOR_X     = 4'd4,
    REG_FOCAL_COLOR_Y     = 4'd5,
    REG_CENTER_COLOR_X    = 4'd6,
    REG_CENTER_COLOR_Y    = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [X_W-1:0]   pixel_x;
    logic [Y_W-1:0]   pixel_y;
    logic [RAW_W-1:0] raw_depth;
  } pixel_t;

  typedef struct packed {
    logic [X_W-1:0]    color_x;
    logic [Y_W-1:0]    color_y;
    logic [ADDR_W-1:0] color_address;
    logic              has_depth;
  } color_t;

  typedef struct packed {
    logic [3:0]  index;
    logic [19:0] value;
  } cfg_word_t;

  typedef struct packed {
    logic [19:0] inv_focal_depth_x;
    logic [19:0] inv_focal_depth_y;
    logic [17:0] center_depth_x;
    logic [16:0] center_depth_y;
    logic [17:0] focal_color_x;
    logic [17:0] focal_color_y;
    logic [17:0] center_color_x;
    logic [16:0] center_color_y;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    inv_focal_depth_x: 20'd28234,
    inv_focal_depth_y: 20'd28386,
    center_depth_x:    18'd86863,
    center_depth_y:    17'd62141,
    focal_color_x:     18'd135479,
    focal_color_y:     18'd134544,
    center_color_x:    18'd84209,
    center_color_y:    17'd68475 };

  // round to nearest by 2^24, halves away from zero
  function automatic logic signed [63:0] round_shr24(logic signed [63:0] v);
    logic signed [63:0] half;
    half = 64'sd8388608;
    if (v >= 0) begin
      return (v + half) >>> 24;
    end
    return -((-v + half) >>> 24);
  endfunction

endpackage

@@ rtl/dtc_stream_if.sv @@
interface dtc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/dtc_cfg_regs.sv @@
module dtc_cfg_regs import dtc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  dtc_stream_if.sink  cfg_i,
  output cfg_regs_t   regs_o
);

  cfg_regs_t regs_q;

  assign cfg_i.ready = 1'b1;
  assign regs_o      = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= CFG_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.data.index))
        REG_INV_FOCAL_DEPTH_X: regs_q.inv_focal_depth_x <= cfg_i.data.value;
        REG_INV_FOCAL_DEPTH_Y: regs_q.inv_focal_depth_y <= cfg_i.data.value;
        REG_CENTER_DEPTH_X:    regs_q.center_depth_x    <= cfg_i.data.value[17:0];
        REG_CENTER_DEPTH_Y:    regs_q.center_depth_y    <= cfg_i.data.value[16:0];
        REG_FOCAL_COLOR_X:     regs_q.focal_color_x     <= cfg_i.data.value[17:0];
        REG_FOCAL_COLOR_Y:     regs_q.focal_color_y     <= cfg_i.data.value[17:0];
        REG_CENTER_COLOR_X:    regs_q.center_color_x    <= cfg_i.data.value[17:0];
        REG_CENTER_COLOR_Y:    regs_q.center_color_y    <= cfg_i.data.value[16:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/dtc_distance_rom.sv @@
module dtc_distance_rom import dtc_pkg::*; #(
  parameter int unsigned Depth = DEF_DISTANCE_ENTRIES,
  localparam int AW = $clog2(Depth)
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [AW-1:0]            addr_i,
  output logic signed [DIST_W-1:0] data_o
);

  typedef logic signed [DIST_W-1:0] rom_t [Depth];

  // series divisors of the sine term, innermost first
  function automatic longint unsigned sin_step(longint unsigned m, int k);
    case (k)
      0: return m / 64'd156;
      1: return m / 64'd110;
      2: return m / 64'd72;
      3: return m / 64'd42;
      4: return m / 64'd20;
      default: return m / 64'd6;
    endcase
  endfunction

  // series divisors of the cosine term, innermost first
  function automatic longint unsigned cos_step(longint unsigned m, int k);
    case (k)
      0: return m / 64'd132;
      1: return m / 64'd90;
      2: return m / 64'd56;
      3: return m / 64'd30;
      4: return m / 64'd12;
      default: return m / 64'd2;
    endcase
  endfunction

  // distance in mm from k1*tan(d/k2+k3)-k4, via Q30 sin/cos series
  function automatic logic signed [DIST_W-1:0] table_entry(int unsigned idx);
    longint unsigned one;
    longint unsigned a, a2, t, s, c, mag, num, den;
    longint theta, u, v;
    one   = 64'd1 << 30;
    theta = longint'((64'(idx) * 64'd2147483648 + 64'd2842) / 64'd5685) + K3_Q30;
    u     = HALF_PI_Q30 - theta;
    a     = (u < 0) ? 64'(-u) : 64'(u);
    a2    = (a * a) >> 30;
    t     = one;
    for (int k = 0; k < 6; k++) begin
      t = one - sin_step((a2 * t) >> 30, k);
    end
    s = (a * t) >> 30;
    t = one;
    for (int k = 0; k < 6; k++) begin
      t = one - cos_step((a2 * t) >> 30, k);
    end
    c = t;
    if (s == 0) begin
      mag = 64'd100000;
    end else begin
      num = 64'd2472 * c + 64'd10 * s;
      den = 64'd20 * s;
      if (num >= den * 64'd100000) begin
        mag = 64'd100000;
      end else begin
        // quotient stays below 2^17 here
        mag = 64'd0;
        for (int b = 16; b >= 0; b--) begin
          if (num >= (den << b)) begin
            num    = num - (den << b);
            mag[b] = 1'b1;
          end
        end
      end
    end
    v = ((u < 0) ? -longint'(mag) : longint'(mag)) - 64'sd37;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    if (v < -64'sd32767) begin
      v = -64'sd32767;
    end
    return DIST_W'(v);
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int unsigned i = 0; i < Depth; i++) begin
      r[i] = (i == NO_READING) ? '0 : table_entry(i);
    end
    return r;
  endfunction

  localparam rom_t ROM_DATA = build_rom();

  logic signed [DIST_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= ROM_DATA[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

@@ rtl/dtc_transform.sv @@
module dtc_transform import dtc_pkg::*; (
  input  logic                     clk_i,
  input  logic [XFORM_LAT-1:0]     en_i,
  input  logic [X_W-1:0]           x_i,
  input  logic [Y_W-1:0]           y_i,
  input  logic signed [DIST_W-1:0] rom_i,
  input  logic                     rng_i,
  input  cfg_regs_t                regs_i,
  output logic signed [NUM_W-1:0]  nx_o,
  output logic signed [NUM_W-1:0]  ny_o,
  output logic signed [QZ_W-1:0]   qz_o,
  output logic                     has_o
);

  // offsets from the depth principal point, times distance
  logic signed [DIST_W-1:0] dist_c;
  logic signed [OX_W-1:0]   ox_c;
  logic signed [OY_W-1:0]   oy_c;
  logic signed [DIST_W-1:0] dist1_q, dist2_q;
  logic signed [OXD_W-1:0]  oxd_q;
  logic signed [OYD_W-1:0]  oyd_q;
  logic signed [PXF_W-1:0]  pxf_q;
  logic signed [PYF_W-1:0]  pyf_q;
  logic signed [D_W-1:0]    d_q [3];
  logic signed [PROD_W-1:0] prod_q [3][3];
  logic signed [QZ_W-1:0]   q_q [3];
  logic signed [SUM_W-1:0]  sum_c [3];
  logic [5:0]               has_q;

  assign dist_c = rng_i ? rom_i : '0;
  assign ox_c   = $signed({1'b0, x_i, 8'd0}) - $signed({1'b0, regs_i.center_depth_x});
  assign oy_c   = $signed({1'b0, y_i, 8'd0}) - $signed({1'b0, regs_i.center_depth_y});

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dist1_q  <= dist_c;
      oxd_q    <= ox_c * dist_c;
      oyd_q    <= oy_c * dist_c;
      has_q[0] <= (dist_c != '0);
    end
    if (en_i[1]) begin
      dist2_q  <= dist1_q;
      pxf_q    <= oxd_q * $signed({1'b0, regs_i.inv_focal_depth_x});
      pyf_q    <= oyd_q * $signed({1'b0, regs_i.inv_focal_depth_y});
      has_q[1] <= has_q[0];
    end
    if (en_i[2]) begin
      d_q[0]   <= D_W'(round_shr24(64'(pxf_q)) - 64'(TRANS_Q8[0]));
      d_q[1]   <= D_W'(round_shr24(64'(pyf_q)) - 64'(TRANS_Q8[1]));
      d_q[2]   <= D_W'(64'(dist2_q) * 64'sd256 - 64'(TRANS_Q8[2]));
      has_q[2] <= has_q[1];
    end
    if (en_i[3]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= d_q[i] * ROT_Q24[i][j];
        end
      end
      has_q[3] <= has_q[2];
    end
    if (en_i[4]) begin
      for (int j = 0; j < 3; j++) begin
        q_q[j] <= QZ_W'(round_shr24(64'(sum_c[j])));
      end
      has_q[4] <= has_q[3];
    end
    if (en_i[5]) begin
      nx_o     <= q_q[0] * $signed({1'b0, regs_i.focal_color_x});
      ny_o     <= q_q[1] * $signed({1'b0, regs_i.focal_color_y});
      qz_o     <= q_q[2];
      has_q[5] <= has_q[4];
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sum_c[j] = SUM_W'(prod_q[0][j]) + SUM_W'(prod_q[1][j]) + SUM_W'(prod_q[2][j]);
    end
  end

  assign has_o = has_q[5];

endmodule

@@ rtl/dtc_divider.sv @@
module dtc_divider import dtc_pkg::*; (
  input  logic                     clk_i,
  input  logic [DIV_LAT-1:0]       en_i,
  input  logic signed [NUM_W-1:0]  num_i,
  input  logic signed [QZ_W-1:0]   den_i,
  output logic signed [QUOT_W-1:0] quot_o
);

  localparam int MagW = QUOT_BITS + 1;

  logic [NUM_W-1:0]     an_q;
  logic [DEN_W-1:0]     ad_q;
  logic                 neg0_q, zero0_q;
  logic [QZ_W-1:0]      den_abs_c;
  logic [REM_W-1:0]     n_sum_c;

  logic [REM_W-1:0]     rem_q [DIV_STAGES+1];
  logic [QUOT_BITS-1:0] quo_q [DIV_STAGES+1];
  logic [DEN_W-1:0]     dv_q  [DIV_STAGES+1];
  logic [DIV_STAGES:0]  sat_q, neg_q, zero_q;
  logic [MagW-1:0]      mag_c;

  assign den_abs_c = den_i[QZ_W-1] ? QZ_W'(-den_i) : QZ_W'(den_i);
  // rounding half of the divisor goes into the dividend
  assign n_sum_c   = REM_W'(an_q) + REM_W'(ad_q >> 1);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      an_q    <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      ad_q    <= {den_abs_c, 8'd0};
      neg0_q  <= num_i[NUM_W-1] ^ den_i[QZ_W-1];
      zero0_q <= (den_i == '0);
    end
    if (en_i[1]) begin
      rem_q[0]  <= n_sum_c;
      quo_q[0]  <= '0;
      dv_q[0]   <= ad_q;
      sat_q[0]  <= (n_sum_c >= (REM_W'(ad_q) << QUOT_BITS));
      neg_q[0]  <= neg0_q;
      zero_q[0] <= zero0_q;
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_step
    logic [REM_W-1:0]     rem_d;
    logic [QUOT_BITS-1:0] quo_d;

    always_comb begin
      rem_d = rem_q[s];
      quo_d = quo_q[s];
      for (int k = 0; k < DIV_STEPS; k++) begin
        if (rem_d >= (REM_W'(dv_q[s]) << (QUOT_BITS - 1 - s * DIV_STEPS - k))) begin
          rem_d = rem_d - (REM_W'(dv_q[s]) << (QUOT_BITS - 1 - s * DIV_STEPS - k));
          quo_d[QUOT_BITS - 1 - s * DIV_STEPS - k] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s+2]) begin
        rem_q[s+1]  <= rem_d;
        quo_q[s+1]  <= quo_d;
        dv_q[s+1]   <= dv_q[s];
        sat_q[s+1]  <= sat_q[s];
        neg_q[s+1]  <= neg_q[s];
        zero_q[s+1] <= zero_q[s];
      end
    end
  end

  // saturate far past the frame; a zero divisor projects to the center
  assign mag_c  = sat_q[DIV_STAGES] ? (MagW'(1) << QUOT_BITS) : {1'b0, quo_q[DIV_STAGES]};
  assign quot_o = zero_q[DIV_STAGES] ? '0 :
                  neg_q[DIV_STAGES]  ? -$signed(QUOT_W'(mag_c)) : $signed(QUOT_W'(mag_c));

endmodule

@@ rtl/depth_to_color_registration_unit.sv @@
// Channel  Dir  Word                                    Handshake
// pix_i    in   pixel_x, pixel_y, raw_depth             valid/ready
// res_o    out  color_x, color_y, color_address, flag   valid/ready
// cfg_i    in   register index, write value             valid/ready, always ready
//
// One pixel per cycle sustained while res_o is ready; a stall on res_o holds the pipe.
// The projection uses a 14-bit restoring divide, two quotient bits per stage.
// Each stage holds its own valid bit and advances when the stage after it frees,
// so bubbles collapse and the input keeps moving while a result waits.
// Reset clears valid bits and restores register defaults; the distance table is
// constant and needs no fill.
`include "depth_to_color_registration_unit_macros.svh"

module depth_to_color_registration_unit import dtc_pkg::*; #(
  parameter int unsigned DISTANCE_ENTRIES = DEF_DISTANCE_ENTRIES,
  parameter int unsigned FRAME_WIDTH      = DEF_FRAME_WIDTH,
  parameter int unsigned FRAME_HEIGHT     = DEF_FRAME_HEIGHT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dtc_stream_if.sink    pix_i,
  dtc_stream_if.source  res_o,
  dtc_stream_if.sink    cfg_i
);

  localparam int RomAW    = $clog2(DISTANCE_ENTRIES);
  localparam int ColW     = $clog2(FRAME_WIDTH);
  localparam int RowW     = $clog2(FRAME_HEIGHT);
  localparam int RowBytes = FRAME_WIDTH * 3;
  localparam logic signed [P_W-1:0] TopX = P_W'((FRAME_WIDTH - 1) * 256);
  localparam logic signed [P_W-1:0] TopY = P_W'((FRAME_HEIGHT - 1) * 256);

  cfg_regs_t regs;

  logic [NUM_STAGES-1:0] v_q, v_d;
  logic [NUM_STAGES:0]   en;

  logic [X_W-1:0]           x0_q;
  logic [Y_W-1:0]           y0_q;
  logic                     rng0_q;
  logic signed [DIST_W-1:0] rom_data;

  logic signed [NUM_W-1:0]  nx, ny;
  logic signed [QZ_W-1:0]   qz;
  logic                     has6;
  logic [ST_CLAMP-1:ST_DIV0] has_q;

  logic signed [QUOT_W-1:0] qx, qy;
  logic signed [P_W-1:0]    px_c, py_c, pcx_c, pcy_c;
  logic [ColW-1:0]          col_q;
  logic [RowW-1:0]          row_q;
  logic                     hasc_q;
  logic [31:0]              addr_c;
  color_t                   out_q;

  // stage k moves when it is empty or stage k+1 moves
  always_comb begin
    en[NUM_STAGES] = res_o.ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin
    v_d = v_q;
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        v_d[k] = (k == 0) ? pix_i.valid : v_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign pix_i.ready = en[ST_ROM];
  assign res_o.valid = v_q[ST_OUT];
  assign res_o.data  = out_q;

  dtc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  always_ff @(posedge clk_i) begin
    if (en[ST_ROM]) begin
      x0_q   <= pix_i.data.pixel_x;
      y0_q   <= pix_i.data.pixel_y;
      rng0_q <= (32'(pix_i.data.raw_depth) < DISTANCE_ENTRIES);
    end
  end

  dtc_distance_rom #(
    .Depth (DISTANCE_ENTRIES)
  ) u_rom (
    .clk_i  (clk_i),
    .en_i   (en[ST_ROM]),
    .addr_i (RomAW'(pix_i.data.raw_depth)),
    .data_o (rom_data)
  );

  dtc_transform u_xform (
    .clk_i  (clk_i),
    .en_i   (en[ST_PROJ:ST_OFS]),
    .x_i    (x0_q),
    .y_i    (y0_q),
    .rom_i  (rom_data),
    .rng_i  (rng0_q),
    .regs_i (regs),
    .nx_o   (nx),
    .ny_o   (ny),
    .qz_o   (qz),
    .has_o  (has6)
  );

  dtc_divider u_div_x (
    .clk_i  (clk_i),
    .en_i   (en[ST_CLAMP-1:ST_DIV0]),
    .num_i  (nx),
    .den_i  (qz),
    .quot_o (qx)
  );

  dtc_divider u_div_y (
    .clk_i  (clk_i),
    .en_i   (en[ST_CLAMP-1:ST_DIV0]),
    .num_i  (ny),
    .den_i  (qz),
    .quot_o (qy)
  );

  // flag travels beside the divider stages
  always_ff @(posedge clk_i) begin
    if (en[ST_DIV0]) begin
      has_q[ST_DIV0] <= has6;
    end
    for (int k = ST_DIV0 + 1; k <= ST_CLAMP - 1; k++) begin
      if (en[k]) begin
        has_q[k] <= has_q[k-1];
      end
    end
  end

  // add the color center, clamp to the frame, drop the fraction
  always_comb begin
    px_c  = (P_W'(qx) <<< 8) + $signed(P_W'({1'b0, regs.center_color_x}));
    py_c  = (P_W'(qy) <<< 8) + $signed(P_W'({1'b0, regs.center_color_y}));
    pcx_c = px_c;
    pcy_c = py_c;
    if (px_c < 0) begin
      pcx_c = '0;
    end else if (px_c > TopX) begin
      pcx_c = TopX;
    end
    if (py_c < 0) begin
      pcy_c = '0;
    end else if (py_c > TopY) begin
      pcy_c = TopY;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_CLAMP]) begin
      col_q  <= pcx_c[8 +: ColW];
      row_q  <= pcy_c[8 +: RowW];
      hasc_q <= has_q[ST_CLAMP-1];
    end
  end

  assign addr_c = 32'(row_q) * 32'(RowBytes) + 32'(col_q) * 32'd3;

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      if (hasc_q) begin
        out_q.color_x       <= X_W'(col_q);
        out_q.color_y       <= Y_W'(row_q);
        out_q.color_address <= addr_c[ADDR_W-1:0];
        out_q.has_depth     <= 1'b1;
      end else begin
        out_q <= '0;
      end
    end
  end

  `DTC_ASSERT_NEXT(a_accept_lands, clk_i, rst_ni, pix_i.valid && pix_i.ready, v_q[ST_ROM], "accepted word not held in first stage")
  `DTC_ASSERT_NEXT(a_div_hold, clk_i, rst_ni, v_q[ST_DIV0] && !en[ST_DIV0], v_q[ST_DIV0], "stalled divider word lost")
  `DTC_ASSERT_NOW(a_black, clk_i, rst_ni, res_o.valid && !res_o.data.has_depth, res_o.data.color_address == '0 && res_o.data.color_x == '0 && res_o.data.color_y == '0, "no-depth word not black")
  `DTC_ASSERT_NOW(a_col_range, clk_i, rst_ni, res_o.valid, 32'(res_o.data.color_x) < 32'(FRAME_WIDTH), "column past frame")
  `DTC_ASSERT_NOW(a_row_range, clk_i, rst_ni, res_o.valid, 32'(res_o.data.color_y) < 32'(FRAME_HEIGHT), "row past frame")

endmodule

@@ verif/dtc_registration_checker.sv @@
module dtc_registration_checker import dtc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  dtc_stream_if pix,
  dtc_stream_if res,
  dtc_stream_if cfg,
  output int    mismatch_cnt_o,
  output int    colors_pending_o
);

  localparam int REG_CNT = 8;
  localparam int REG_BITS [REG_CNT] = '{20, 20, 18, 17, 18, 18, 18, 17};
  localparam longint TRANS [3] = '{5116, -191, -2795};
  localparam longint ROT [3][3] = '{
    '{16774637, 21199, -293387},
    '{-24795, 16775939, -205544},
    '{293105, 205946, 16773391}};

  longint      distance_mm [DEF_DISTANCE_ENTRIES];
  longint      calib [REG_CNT];
  color_t      expected_colors [$];
  int          mismatch_cnt;

  assign mismatch_cnt_o   = mismatch_cnt;
  assign colors_pending_o = expected_colors.size();

  function automatic longint unsigned mul_q30(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic longint distance_of(int unsigned i);
    longint unsigned sd [6] = '{156, 110, 72, 42, 20, 6};
    longint unsigned cd [6] = '{132, 90, 56, 30, 12, 2};
    longint unsigned one, a, a2, t, s, c, mag;
    longint theta, u, v;
    one = 64'd1 << 30;
    theta = longint'((longint'(i) * 64'd2147483648 + 64'd2842) / 64'd5685) + K3_Q30;
    u = HALF_PI_Q30 - theta;
    a = (u < 0) ? -u : u;
    a2 = mul_q30(a, a);
    t = one;
    for (int k = 0; k < 6; k++) t = one - mul_q30(a2, t) / sd[k];
    s = mul_q30(a, t);
    t = one;
    for (int k = 0; k < 6; k++) t = one - mul_q30(a2, t) / cd[k];
    c = t;
    if (s == 0) begin
      mag = 100000;
    end else begin
      mag = (2 * 1236 * c + 10 * s) / (20 * s);
      if (mag > 100000) mag = 100000;
    end
    v = ((u < 0) ? -longint'(mag) : longint'(mag)) - 37;
    if (v > 32767) v = 32767;
    if (v < -32767) v = -32767;
    return v;
  endfunction

  function automatic longint round_shift24(longint v);
    if (v >= 0) return (v + 64'sd8388608) >>> 24;
    return -((-v + 64'sd8388608) >>> 24);
  endfunction

  function automatic longint nearest_div(longint n, longint d);
    longint unsigned an, ad;
    longint q;
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    q = longint'((an + ad / 2) / ad);
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic longint to_frame(longint num, longint focal, longint den,
                                      longint center, longint size);
    longint q, p, top;
    q = 0;
    top = (size - 1) * 256;
    if (den != 0) q = nearest_div(num * focal, den * 256);
    if (q > (64'sd1 <<< 40)) q = 64'sd1 <<< 40;
    if (q < -(64'sd1 <<< 40)) q = -(64'sd1 <<< 40);
    p = q * 256 + center;
    if (p < 0) p = 0;
    if (p > top) p = top;
    return p / 256;
  endfunction

  function automatic color_t register_pixel(pixel_t px);
    color_t r;
    longint depth_mm, col, row;
    longint pt [3], dp [3], rp [3];
    r = '0;
    depth_mm = 0;
    if (px.raw_depth != NO_READING && px.raw_depth < DEF_DISTANCE_ENTRIES)
      depth_mm = distance_mm[px.raw_depth];
    if (depth_mm == 0) return r;
    pt[0] = round_shift24((longint'(px.pixel_x) * 256 - calib[REG_CENTER_DEPTH_X]) * depth_mm
                          * calib[REG_INV_FOCAL_DEPTH_X]);
    pt[1] = round_shift24((longint'(px.pixel_y) * 256 - calib[REG_CENTER_DEPTH_Y]) * depth_mm
                          * calib[REG_INV_FOCAL_DEPTH_Y]);
    pt[2] = depth_mm * 256;
    for (int j = 0; j < 3; j++) dp[j] = pt[j] - TRANS[j];
    for (int j = 0; j < 3; j++)
      rp[j] = round_shift24(dp[0] * ROT[0][j] + dp[1] * ROT[1][j] + dp[2] * ROT[2][j]);
    col = to_frame(rp[0], calib[REG_FOCAL_COLOR_X], rp[2], calib[REG_CENTER_COLOR_X],
                   DEF_FRAME_WIDTH);
    row = to_frame(rp[1], calib[REG_FOCAL_COLOR_Y], rp[2], calib[REG_CENTER_COLOR_Y],
                   DEF_FRAME_HEIGHT);
    r.color_x = col[X_W-1:0];
    r.color_y = row[Y_W-1:0];
    r.color_address = ADDR_W'(row * (DEF_FRAME_WIDTH * 3) + col * 3);
    r.has_depth = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    mismatch_cnt++;
  endtask

  initial begin
    mismatch_cnt = 0;
    for (int i = 0; i < DEF_DISTANCE_ENTRIES; i++)
      distance_mm[i] = (i == NO_READING) ? 0 : distance_of(i);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib[REG_INV_FOCAL_DEPTH_X] <= CFG_RESET.inv_focal_depth_x;
      calib[REG_INV_FOCAL_DEPTH_Y] <= CFG_RESET.inv_focal_depth_y;
      calib[REG_CENTER_DEPTH_X]    <= CFG_RESET.center_depth_x;
      calib[REG_CENTER_DEPTH_Y]    <= CFG_RESET.center_depth_y;
      calib[REG_FOCAL_COLOR_X]     <= CFG_RESET.focal_color_x;
      calib[REG_FOCAL_COLOR_Y]     <= CFG_RESET.focal_color_y;
      calib[REG_CENTER_COLOR_X]    <= CFG_RESET.center_color_x;
      calib[REG_CENTER_COLOR_Y]    <= CFG_RESET.center_color_y;
    end else begin
      if (cfg.valid && cfg.ready && cfg.data.index < REG_CNT)
        calib[cfg.data.index] <= cfg.data.value & ((64'd1 << REG_BITS[cfg.data.index]) - 1);
      if (pix.valid && pix.ready) expected_colors.push_back(register_pixel(pix.data));
      if (res.valid && res.ready) begin
        if (expected_colors.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          color_t want;
          want = expected_colors.pop_front();
          if (res.data.color_x != want.color_x)
            report_mismatch("color_x", res.data.color_x, want.color_x);
          if (res.data.color_y != want.color_y)
            report_mismatch("color_y", res.data.color_y, want.color_y);
          if (res.data.color_address != want.color_address)
            report_mismatch("color_address", res.data.color_address, want.color_address);
          if (res.data.has_depth != want.has_depth)
            report_mismatch("has_depth", res.data.has_depth, want.has_depth);
        end
      end
    end
  end

endmodule

@@ verif/tb_depth_to_color_registration_unit.sv @@
module tb_depth_to_color_registration_unit import dtc_pkg::*; ();

  localparam int HOLD_CYCLES = 24;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASES      = 8;
  localparam int PER_PHASE   = 230;

  logic clk_i;
  logic rst_ni;
  int   mismatch_cnt;
  int   colors_pending;
  int   idle_pct;
  int   stall_pct;
  int   quiet_cycles;

  dtc_stream_if #(.payload_t(pixel_t))    pix ();
  dtc_stream_if #(.payload_t(color_t))    res ();
  dtc_stream_if #(.payload_t(cfg_word_t)) cfg ();

  depth_to_color_registration_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  dtc_registration_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pix              (pix),
    .res              (res),
    .cfg              (cfg),
    .mismatch_cnt_o   (mismatch_cnt),
    .colors_pending_o (colors_pending)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(negedge clk_i) begin
    res.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pix.valid && pix.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** depth_to_color_registration_unit: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_pixel(logic [X_W-1:0] x, logic [Y_W-1:0] y, logic [RAW_W-1:0] raw);
    while ($urandom_range(99) < idle_pct) begin
      pix.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.data  <= '{pixel_x: x, pixel_y: y, raw_depth: raw};
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random_pixel();
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [RAW_W-1:0] raw;
    int               pick;
    x = ($urandom_range(19) == 0) ? X_W'($urandom) : X_W'($urandom_range(639));
    y = ($urandom_range(19) == 0) ? Y_W'($urandom) : Y_W'($urandom_range(479));
    pick = $urandom_range(99);
    if (pick < 10)      raw = RAW_W'(NO_READING);
    else if (pick < 15) raw = RAW_W'($urandom_range(15));
    else if (pick < 20) raw = RAW_W'($urandom_range(2046, 2030));
    else                raw = RAW_W'($urandom);
    send_pixel(x, y, raw);
  endtask

  // drain the pipe, then hold off so nothing is in flight during a register write
  task automatic wait_idle();
    pix.valid <= 1'b0;
    while (colors_pending != 0) @(negedge clk_i);
    repeat (HOLD_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_calib(int mode);
    cfg_reg_e  r;
    int        bits [8] = '{20, 20, 18, 17, 18, 18, 18, 17};
    int        dflt [8] = '{28234, 28386, 86863, 62141, 135479, 134544, 84209, 68475};
    logic [19:0] val, mask;
    for (int k = 0; k < 8; k++) begin
      r = cfg_reg_e'(k);
      mask = 20'((32'd1 << bits[k]) - 1);
      case (mode)
        0: val = 20'(dflt[k]);
        1: val = '0;
        2: val = mask;
        3: val = 20'($urandom) & mask;
        default: val = 20'(dflt[k] + $urandom_range(4096) - 2048) & mask;
      endcase
      cfg.valid <= 1'b1;
      cfg.data  <= '{index: r, value: val};
      @(posedge clk_i);
      while (!cfg.ready) @(posedge clk_i);
      @(negedge clk_i);
    end
    cfg.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    rst_ni       = 1'b0;
    pix.valid    = 1'b0;
    pix.data     = '0;
    cfg.valid    = 1'b0;
    cfg.data     = '0;
    res.ready    = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // field extremes and the no-reading code under reset calibration
    send_pixel(0, 0, 0);
    send_pixel(639, 479, 0);
    send_pixel(0, 479, 2046);
    send_pixel(639, 0, 2046);
    send_pixel(320, 240, RAW_W'(NO_READING));
    send_pixel(10'h3FF, 9'h1FF, 1);
    send_pixel(10'h3FF, 9'h1FF, RAW_W'(NO_READING));
    send_pixel(512, 256, 1024);
    send_pixel(0, 0, 1500);
    send_pixel(639, 479, 1800);
    send_pixel(1, 1, 2000);
    send_pixel(320, 240, 700);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      write_calib(ph);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      for (int n = 0; n < PER_PHASE; n++) begin
        if (ph == 3 && n == PER_PHASE / 2) begin
          pix.valid <= 1'b0;
          while (colors_pending != 0) @(negedge clk_i);
        end
        send_random_pixel();
      end
    end

    pix.valid <= 1'b0;
    while (colors_pending != 0) @(negedge clk_i);
    repeat (HOLD_CYCLES) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("** depth_to_color_registration_unit: PASSED **");
    end else begin
      $display("** depth_to_color_registration_unit: FAILED **");
    end
    $finish;
  end

endmodule
